// ----- hw/rtl/pfa_pkg.sv -----
// pfa_pkg: shared types and constants of the partition fit allocator
// operation and fit mode codes, register indexes, control and status structs
// no dependencies
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int OP_W         = 2;
    localparam int INDEX_W      = 6;
    localparam int IDENT_W      = 16;
    localparam int FIELD_SIZE_W = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 7;
    localparam int MODE_W       = 2;
    localparam int BCOUNT_W     = 7;
    localparam int IN_DATA_W    = 72;
    localparam int OUT_DATA_W   = 48;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic free_all;
        logic start;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic last_addr;
        logic out_free;
    } t_stat;

endpackage

// ----- hw/rtl/partition_fit_allocator.sv -----
// partition_fit_allocator: top level of the fixed-partition fit allocator
// joins pfa_ctrl and pfa_dpath; uses pfa_pkg
//
// Usage: configure fit_mode (index 0) and block_count (index 1) on the write
// port while idle. Items enter on the s_axis channel, the operation in tuser.
// A load item writes one table entry and frees it; a free-all item clears
// every taken flag. Both are taken in the idle state and give no result.
// An allocate item scans the active entries through the table memory's
// single read port, one entry per cycle, then passes the last and done
// states, or goes straight to done with no active entry. Its result is
// loaded into the result register on leaving done; idle takes the next item.
// One result per allocate item leaves on the m_axis channel; granted is
// carried in tuser. While the receiver stalls, the result register holds and
// the block keeps taking load and free-all items, and a following allocate
// waits at its last stage until the register is free.
// Reset clears the taken flags, the configuration and the result valid
// flag; table entries are undefined until loaded.
`timescale 1ns / 1ps

module partition_fit_allocator #(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // block_index, block_ident, block_size, process_ident, request_size, pad
    input  logic [pfa_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // operation
    input  logic [pfa_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // owner_ident, granted_block, leftover_size
    output logic [pfa_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // granted
    output logic [0:0]                          m_axis_tuser
);
    import pfa_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    logic [IDENT_W-1:0]      w_owner;
    logic                    w_granted;
    logic [IDENT_W-1:0]      w_block;
    logic [FIELD_SIZE_W-1:0] w_left;

    pfa_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .i_op   (s_axis_tuser),
        .o_ready(s_axis_tready),
        .o_cmd  (w_cmd),
        .i_stat (w_stat)
    );

    pfa_dpath #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_block_index  (s_axis_tdata[5:0]),
        .i_block_ident  (s_axis_tdata[21:6]),
        .i_block_size   (s_axis_tdata[37:22]),
        .i_process_ident(s_axis_tdata[53:38]),
        .i_request_size (s_axis_tdata[69:54]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_owner_ident  (w_owner),
        .o_granted      (w_granted),
        .o_granted_block(w_block),
        .o_leftover_size(w_left)
    );

    assign m_axis_tdata = {w_left, w_block, w_owner};
    assign m_axis_tuser = w_granted;

endmodule

// ----- hw/rtl/pfa_ram.sv -----
// pfa_ram: generic single write port, single read port memory
// registered read data, no dependencies
`timescale 1ns / 1ps

module pfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/pfa_ctrl.sv -----
// pfa_ctrl: controller state machine of the partition fit allocator
// sequences load, free-all and the allocate table scan; uses pfa_pkg
`timescale 1ns / 1ps

module pfa_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [pfa_pkg::OP_W-1:0]   i_op,
    output logic                       o_ready,
    output pfa_pkg::t_cmd              o_cmd,
    input  pfa_pkg::t_stat             i_stat
);
    import pfa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_op == OP_ALLOC) begin
                    n_state = i_stat.count_zero ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.last_addr) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready        = 1'b1;
                o_cmd.load     = i_valid && i_op == OP_LOAD;
                o_cmd.free_all = i_valid && i_op == OP_FREE;
                o_cmd.start    = i_valid && i_op == OP_ALLOC;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_LAST: begin
            end
            ST_DONE: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_last_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LAST |=> r_state == ST_DONE)
        else $error("scan end did not lead to result stage");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> !i_stat.count_zero)
        else $error("scanning an empty table");
`endif

endmodule

// ----- hw/rtl/pfa_dpath.sv -----
// pfa_dpath: datapath of the partition fit allocator
// block table memory, taken flags, fit search and result register
// uses pfa_pkg and pfa_ram
`timescale 1ns / 1ps

module pfa_dpath #(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pfa_pkg::t_cmd                     i_cmd,
    output pfa_pkg::t_stat                    o_stat,
    input  logic                              i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [pfa_pkg::INDEX_W-1:0]       i_block_index,
    input  logic [pfa_pkg::IDENT_W-1:0]       i_block_ident,
    input  logic [pfa_pkg::FIELD_SIZE_W-1:0]  i_block_size,
    input  logic [pfa_pkg::IDENT_W-1:0]       i_process_ident,
    input  logic [pfa_pkg::FIELD_SIZE_W-1:0]  i_request_size,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [pfa_pkg::IDENT_W-1:0]       o_owner_ident,
    output logic                              o_granted,
    output logic [pfa_pkg::IDENT_W-1:0]       o_granted_block,
    output logic [pfa_pkg::FIELD_SIZE_W-1:0]  o_leftover_size
);
    import pfa_pkg::*;

    localparam int ADDR_W = MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int WORD_W = IDENT_W + SIZE_BITS;

    logic [MODE_W-1:0]    r_fit_mode;
    logic [BCOUNT_W-1:0]  r_block_count;
    logic [MAX_BLOCKS-1:0] r_taken;

    logic [ADDR_W-1:0]    r_addr;
    logic                 r_eval_v;
    logic [ADDR_W-1:0]    r_eval_idx;
    logic [SIZE_BITS-1:0] r_req;
    logic [IDENT_W-1:0]   r_pid;
    logic                 r_found;
    logic [ADDR_W-1:0]    r_pick;
    logic [SIZE_BITS-1:0] r_best_size;
    logic [IDENT_W-1:0]   r_best_ident;

    logic                    r_out_valid;
    logic [IDENT_W-1:0]      r_out_owner;
    logic                    r_out_granted;
    logic [IDENT_W-1:0]      r_out_block;
    logic [FIELD_SIZE_W-1:0] r_out_left;

    logic [CNT_W-1:0]     w_count;
    logic                 w_idx_ok;
    logic [ADDR_W-1:0]    w_waddr;
    logic [WORD_W-1:0]    w_wdata;
    logic [WORD_W-1:0]    w_rdata;
    logic [SIZE_BITS-1:0] w_rd_size;
    logic [IDENT_W-1:0]   w_rd_ident;
    logic                 w_fits;
    logic                 w_better;

    // a block count beyond the table size acts as the table size
    assign w_count = (int'(r_block_count) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                        : CNT_W'(r_block_count);
    assign w_idx_ok = int'(i_block_index) < MAX_BLOCKS;
    assign w_waddr  = ADDR_W'(i_block_index);
    assign w_wdata  = {i_block_ident, SIZE_BITS'(i_block_size)};

    pfa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load && w_idx_ok),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    assign w_rd_size  = w_rdata[SIZE_BITS-1:0];
    assign w_rd_ident = w_rdata[SIZE_BITS +: IDENT_W];

    assign w_fits   = !r_taken[r_eval_idx] && w_rd_size >= r_req;
    assign w_better = !r_found
                   || (r_fit_mode == FIT_BEST  && w_rd_size < r_best_size)
                   || (r_fit_mode == FIT_WORST && w_rd_size > r_best_size);

    assign o_stat.count_zero = w_count == '0;
    assign o_stat.last_addr  = CNT_W'(r_addr) == CNT_W'(w_count - CNT_W'(1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= FIT_FIRST;
            r_block_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIT_MODE:    r_fit_mode    <= i_cfg_data[MODE_W-1:0];
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[BCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
        end else if (i_cmd.free_all) begin
            r_taken <= '0;
        end else if (i_cmd.load && w_idx_ok) begin
            r_taken[w_waddr] <= 1'b0;
        end else if (i_cmd.finish && r_found) begin
            r_taken[r_pick] <= 1'b1;
        end
    end

    // scan: address issued to the table memory, entry judged from its registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval_v <= 1'b0;
            r_found  <= 1'b0;
            r_addr   <= '0;
        end else begin
            r_eval_v <= i_cmd.scan;
            if (i_cmd.start) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (r_eval_v && w_fits && w_better) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req <= SIZE_BITS'(i_request_size);
            r_pid <= i_process_ident;
        end
        if (i_cmd.scan) begin
            r_eval_idx <= r_addr;
        end
        if (!i_cmd.start && r_eval_v && w_fits && w_better) begin
            r_pick       <= r_eval_idx;
            r_best_size  <= w_rd_size;
            r_best_ident <= w_rd_ident;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_owner   <= r_pid;
            r_out_granted <= r_found;
            r_out_block   <= r_found ? r_best_ident : '0;
            r_out_left    <= r_found ? FIELD_SIZE_W'(r_best_size - r_req) : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_owner_ident   = r_out_owner;
    assign o_granted       = r_out_granted;
    assign o_granted_block = r_out_block;
    assign o_leftover_size = r_out_left;

`ifndef NO_ASSERTIONS
    a_claim_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_taken & ~$past(r_taken)) != '0 |-> $past(i_cmd.finish && r_found))
        else $error("taken flag set outside a grant");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.finish))
        else $error("result appeared without a finished search");

    a_refusal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_granted |-> r_out_block == '0 && r_out_left == '0)
        else $error("refused request carries block or leftover");
`endif

endmodule

// ----- tb/sv/partition_fit_allocator_tb.sv -----
// partition_fit_allocator_tb: self-checking bench for the partition fit allocator
// directed and random load, allocate and free-all items against an in-bench table model
// depends on pfa_pkg and partition_fit_allocator
`timescale 1ns / 1ps

module partition_fit_allocator_tb;

    import pfa_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 70;
    localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
    localparam logic [MODE_W-1:0] FIT_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic [IN_DATA_W-1:0] data;
    } t_item;

    typedef struct {
        logic [IDENT_W-1:0]      owner;
        logic                    granted;
        logic [IDENT_W-1:0]      block;
        logic [FIELD_SIZE_W-1:0] leftover;
    } t_grant;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    // table model
    logic [FIELD_SIZE_W-1:0] size_mem  [TABLE_DEPTH];
    logic [IDENT_W-1:0]      ident_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  taken_mask = '0;
    logic [TABLE_DEPTH-1:0]  loaded_mask = '0;
    logic [MODE_W-1:0]       mode_reg = FIT_FIRST;
    logic [BCOUNT_W-1:0]     count_reg = '0;

    t_item  pending_items [$];
    t_grant grant_expected [$];

    int  queued_total   = 0;
    int  accepted_total = 0;
    int  errors         = 0;
    int  send_gap       = 0;
    int  recv_wait      = 0;
    int  hold_left      = 0;
    int  idle_cycles    = 0;
    bit  no_idle        = 1'b0;
    bit  hold_request   = 1'b0;
    bit  hold_used      = 1'b0;

    partition_fit_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic int active_entries();
        return (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
    endfunction

    // one accepted item through the table model
    task automatic allocate_predict(input logic [OP_W-1:0] op,
                                    input logic [IN_DATA_W-1:0] data);
        logic [INDEX_W-1:0]      idx;
        logic [FIELD_SIZE_W-1:0] req;
        bit                      found;
        int                      pick;
        int                      active;
        t_grant                  res;
        idx    = data[5:0];
        req    = data[69:54];
        found  = 1'b0;
        pick   = 0;
        active = active_entries();
        case (op)
            OP_LOAD: begin
                ident_mem[idx]  = data[21:6];
                size_mem[idx]   = data[37:22];
                taken_mask[idx] = 1'b0;
            end
            OP_FREE: begin
                taken_mask = '0;
            end
            OP_ALLOC: begin
                for (int i = 0; i < active; i++) begin
                    if (!taken_mask[i] && size_mem[i] >= req) begin
                        if (!found) begin
                            found = 1'b1;
                            pick  = i;
                        end else if (mode_reg == FIT_BEST && size_mem[i] < size_mem[pick]) begin
                            pick = i;
                        end else if (mode_reg == FIT_WORST && size_mem[i] > size_mem[pick]) begin
                            pick = i;
                        end
                    end
                end
                res.owner = data[53:38];
                if (found) begin
                    taken_mask[pick] = 1'b1;
                    res.granted  = 1'b1;
                    res.block    = ident_mem[pick];
                    res.leftover = size_mem[pick] - req;
                end else begin
                    res.granted  = 1'b0;
                    res.block    = '0;
                    res.leftover = '0;
                end
                grant_expected.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    // an allocate never scans an entry that was never loaded: load it first instead
    task automatic queue_item(input logic [OP_W-1:0] op, input int idx,
                              input logic [15:0] ident, input logic [15:0] bsize,
                              input logic [15:0] pid, input logic [15:0] req);
        t_item it;
        int    gap_idx;
        gap_idx = -1;
        if (op == OP_ALLOC) begin
            for (int i = active_entries() - 1; i >= 0; i--) begin
                if (!loaded_mask[i]) begin
                    gap_idx = i;
                end
            end
        end
        if (gap_idx >= 0) begin
            op  = OP_LOAD;
            idx = gap_idx;
        end
        if (op == OP_LOAD) begin
            loaded_mask[idx] = 1'b1;
        end
        it.op   = op;
        it.data = {2'b00, req, pid, bsize, ident, idx[5:0]};
        pending_items.push_back(it);
        queued_total++;
    endtask

    task automatic wait_idle();
        while (accepted_total != queued_total || grant_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        if (idx == CFG_FIT_MODE) begin
            mode_reg = value[MODE_W-1:0];
        end else begin
            count_reg = value;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic start_phase(input logic [MODE_W-1:0] mode,
                               input logic [BCOUNT_W-1:0] count);
        wait_idle();
        write_reg(CFG_FIT_MODE, {5'd0, mode});
        write_reg(CFG_BLOCK_COUNT, count);
    endtask

    // small sizes give contention, the rest covers the full range
    function automatic logic [15:0] draw_size();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            return 16'($urandom_range(0, 64));
        end else if (sel == 8) begin
            return 16'h0000;
        end else if (sel == 9) begin
            return 16'hffff;
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic queue_random_item();
        int sel;
        int idx;
        int active;
        sel    = $urandom_range(0, 99);
        active = active_entries();
        if (active > 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, active - 1);
        end else begin
            idx = $urandom_range(0, TABLE_DEPTH - 1);
        end
        if (sel < 30) begin
            queue_item(OP_LOAD, idx, 16'($urandom), draw_size(), 16'($urandom), 16'($urandom));
        end else if (sel < 88) begin
            queue_item(OP_ALLOC, idx, 16'($urandom), 16'($urandom), 16'($urandom), draw_size());
        end else if (sel < 96) begin
            queue_item(OP_FREE, idx, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            queue_item(OP_UNUSED, idx, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // sender
    always @(posedge i_clk) begin : sender
        logic  next_valid;
        t_item cur;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else begin
            next_valid = s_axis_tvalid && !s_axis_tready;
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_items.size() != 0) begin
                    cur = pending_items.pop_front();
                    s_axis_tdata <= cur.data;
                    s_axis_tuser <= cur.op;
                    send_gap     <= no_idle ? 0 : $urandom_range(0, 6);
                    next_valid   = 1'b1;
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // input side model update
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            allocate_predict(s_axis_tuser, s_axis_tdata);
            accepted_total <= accepted_total + 1;
        end
    end

    // receiver and result check
    always @(posedge i_clk) begin : receiver
        int     wait_n;
        t_grant want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait     <= 0;
            hold_left     <= 0;
        end else begin
            wait_n = recv_wait;
            if (m_axis_tvalid && m_axis_tready) begin
                if (grant_expected.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h / %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    errors++;
                end else begin
                    want = grant_expected.pop_front();
                    check_field("owner_ident", want.owner, m_axis_tdata[15:0]);
                    check_field("granted", 16'(want.granted), 16'(m_axis_tuser[0]));
                    check_field("granted_block", want.block, m_axis_tdata[31:16]);
                    check_field("leftover_size", want.leftover, m_axis_tdata[47:32]);
                end
                wait_n = no_idle ? 0 : $urandom_range(0, 6);
            end else if (wait_n > 0) begin
                wait_n = wait_n - 1;
            end
            recv_wait <= wait_n;
            if (hold_request && !hold_used) begin
                hold_used     <= 1'b1;
                hold_left     <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (wait_n == 0);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no progress", $time);
            $display("partition_fit_allocator regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [MODE_W-1:0]   phase_mode  [0:8];
        logic [BCOUNT_W-1:0] phase_count [0:8];
        phase_mode  = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_UNUSED, FIT_BEST,
                        FIT_WORST, FIT_FIRST, FIT_BEST, FIT_WORST};
        phase_count = '{7'd8, 7'd16, 7'd1, 7'd5, 7'd64, 7'd127, 7'd0, 7'd12, 7'd3};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no entries in use, unknown operation
        queue_item(OP_ALLOC, 0, 16'h0000, 16'h0000, 16'hffff, 16'h0000);
        queue_item(OP_UNUSED, 63, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

        start_phase(FIT_FIRST, 7'd4);
        queue_item(OP_LOAD, 0, 16'hffff, 16'hffff, 16'h0000, 16'h0000);
        queue_item(OP_LOAD, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_item(OP_LOAD, 2, 16'h1234, 16'd100, 16'h0000, 16'h0000);
        queue_item(OP_LOAD, 3, 16'habcd, 16'd100, 16'h0000, 16'h0000);
        queue_item(OP_LOAD, 63, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        queue_item(OP_ALLOC, 0, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
        queue_item(OP_ALLOC, 0, 16'h0000, 16'h0000, 16'h0001, 16'd100);
        queue_item(OP_ALLOC, 0, 16'h0000, 16'h0000, 16'h0002, 16'h0000);
        queue_item(OP_ALLOC, 0, 16'h0000, 16'h0000, 16'h0003, 16'h0000);
        queue_item(OP_ALLOC, 0, 16'h0000, 16'h0000, 16'h0004, 16'h0000);
        // reload of a taken entry frees it
        queue_item(OP_LOAD, 0, 16'h5555, 16'd50, 16'h0000, 16'h0000);
        queue_item(OP_ALLOC, 0, 16'h0000, 16'h0000, 16'h0005, 16'd51);
        queue_item(OP_ALLOC, 0, 16'h0000, 16'h0000, 16'h0006, 16'd50);
        queue_item(OP_FREE, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        start_phase(FIT_BEST, 7'd4);
        queue_item(OP_ALLOC, 0, 16'h0000, 16'h0000, 16'h0007, 16'd1);
        queue_item(OP_ALLOC, 0, 16'h0000, 16'h0000, 16'h0008, 16'd60);

        start_phase(FIT_WORST, 7'd4);
        queue_item(OP_FREE, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_item(OP_ALLOC, 0, 16'h0000, 16'h0000, 16'h0009, 16'h0000);
        queue_item(OP_ALLOC, 0, 16'h0000, 16'h0000, 16'h000a, 16'h0000);
        queue_item(OP_ALLOC, 0, 16'h0000, 16'h0000, 16'h000b, 16'h0000);

        for (int p = 0; p < 9; p++) begin
            start_phase(phase_mode[p], phase_count[p]);
            no_idle = (p % 3 == 0);
            if (p == 2) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                queue_random_item();
            end
        end

        wait_idle();
        repeat (70) @(posedge i_clk);
        if (errors == 0) begin
            $display("partition_fit_allocator regression: pass");
        end else begin
            $display("partition_fit_allocator regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_ram.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/pfa_dpath.sv
hw/rtl/partition_fit_allocator.sv
tb/sv/partition_fit_allocator_tb.sv
